// ----- rtl/tdec_pkg.sv -----
// Shared types, codes and color expansion functions for the tiled texture decoder.
// No dependencies.
package tdec_pkg;

    typedef enum logic [1:0] {
        FMT_RGBA8  = 2'd0,
        FMT_RGB5A3 = 2'd1,
        FMT_C8     = 2'd2,
        FMT_IA8    = 2'd3
    } fmt_t;

    // Config register indexes
    localparam logic [1:0] CFG_FORMAT  = 2'd0;
    localparam logic [1:0] CFG_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_PALETTE = 2'd3;

    // Work kinds passed from front to back
    typedef enum logic [1:0] {
        K_DIRECT    = 2'd0,  // color fields already final
        K_WORD      = 2'd1,  // rgb5a3 word in {green, blue}
        K_INDEX     = 2'd2,  // palette index in blue
        K_PAL_WRITE = 2'd3   // palette index in alpha, word in {green, blue}
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [10:0] px;
        logic [10:0] py;
        logic [7:0]  alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } rec_t;

    typedef struct packed {
        logic [10:0] px;
        logic [10:0] py;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } pix_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    // floor(v * 255 / 31)
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0] res;
        begin
            case (v)
                5'd0:  res = 8'd0;
                5'd1:  res = 8'd8;
                5'd2:  res = 8'd16;
                5'd3:  res = 8'd24;
                5'd4:  res = 8'd32;
                5'd5:  res = 8'd41;
                5'd6:  res = 8'd49;
                5'd7:  res = 8'd57;
                5'd8:  res = 8'd65;
                5'd9:  res = 8'd74;
                5'd10: res = 8'd82;
                5'd11: res = 8'd90;
                5'd12: res = 8'd98;
                5'd13: res = 8'd106;
                5'd14: res = 8'd115;
                5'd15: res = 8'd123;
                5'd16: res = 8'd131;
                5'd17: res = 8'd139;
                5'd18: res = 8'd148;
                5'd19: res = 8'd156;
                5'd20: res = 8'd164;
                5'd21: res = 8'd172;
                5'd22: res = 8'd180;
                5'd23: res = 8'd189;
                5'd24: res = 8'd197;
                5'd25: res = 8'd205;
                5'd26: res = 8'd213;
                5'd27: res = 8'd222;
                5'd28: res = 8'd230;
                5'd29: res = 8'd238;
                5'd30: res = 8'd246;
                default: res = 8'd255;
            endcase
            return res;
        end
    endfunction

    // floor(v * 255 / 7)
    function automatic logic [7:0] expand3(input logic [2:0] v);
        logic [7:0] res;
        begin
            case (v)
                3'd0: res = 8'd0;
                3'd1: res = 8'd36;
                3'd2: res = 8'd72;
                3'd3: res = 8'd109;
                3'd4: res = 8'd145;
                3'd5: res = 8'd182;
                3'd6: res = 8'd218;
                default: res = 8'd255;
            endcase
            return res;
        end
    endfunction

    // 4-bit expansion is exact: v * 17
    function automatic rgba_t expand_word(input logic [15:0] w);
        rgba_t c;
        begin
            if (w[15]) begin
                c.red   = expand5(w[14:10]);
                c.green = expand5(w[9:5]);
                c.blue  = expand5(w[4:0]);
                c.alpha = 8'd255;
            end
            else begin
                c.alpha = expand3(w[14:12]);
                c.red   = {w[11:8], w[11:8]};
                c.green = {w[7:4], w[7:4]};
                c.blue  = {w[3:0], w[3:0]};
            end
            return c;
        end
    endfunction

endpackage

// ----- rtl/tdec_queue.sv -----
// Two-entry synchronous queue used between decoder stages.
// No dependencies.
module tdec_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/tdec_front.sv -----
// Front end: accepts source bytes and palette writes, tracks tile position,
// buffers the RGBA8 AR half and builds work records. Depends on tdec_pkg.
module tdec_front
    import tdec_pkg::*;
#(
    parameter int MAX_DIMENSION = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  palette_index,
    input  logic [15:0] palette_value,
    input  logic [1:0]  texture_format,
    input  logic [11:0] image_width,
    input  logic [11:0] image_height,
    output logic        q_push,
    output rec_t        q_rec
);

    logic [5:0]  bit_reg, bit_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [7:0]  held_reg;
    logic [7:0]  even_bank_reg [16];
    logic [7:0]  odd_bank_reg [16];

    fmt_t        fmt;
    logic [5:0]  b;
    logic        last;
    logic        wide;
    logic [3:0]  pidx;
    logic [4:0]  pos;
    logic        have;
    logic        hold_wr;
    logic        even_wr;
    logic        odd_wr;
    logic [12:0] px_full;
    logic [12:0] py_full;
    logic [12:0] col_sum;
    logic [12:0] row_sum;
    logic        size_ok;
    logic        emit;
    logic        byte_acc;
    rec_t        pix_rec;

    assign byte_acc = accept && !mode;

    always_comb
    begin
        fmt     = fmt_t'(texture_format);
        b       = (fmt == FMT_RGBA8) ? bit_reg : {1'b0, bit_reg[4:0]};
        last    = (fmt == FMT_RGBA8) ? (b == 6'd63) : (b[4:0] == 5'd31);
        wide    = (fmt == FMT_C8);
        pidx    = b[4:1];
        pos     = {1'b0, pidx};
        have    = 1'b0;
        hold_wr = 1'b0;
        even_wr = 1'b0;
        odd_wr  = 1'b0;
        pix_rec = '0;
        pix_rec.kind = K_DIRECT;
        case (fmt)
            FMT_RGBA8:
            begin
                if (!b[5])
                begin
                    even_wr = !b[0];
                    odd_wr  = b[0];
                end
                else if (!b[0])
                begin
                    hold_wr = 1'b1;
                end
                else
                begin
                    have          = 1'b1;
                    pix_rec.alpha = even_bank_reg[pidx];
                    pix_rec.red   = odd_bank_reg[pidx];
                    pix_rec.green = held_reg;
                    pix_rec.blue  = data_byte;
                end
            end
            FMT_RGB5A3:
            begin
                if (!b[0])
                begin
                    hold_wr = 1'b1;
                end
                else
                begin
                    have          = 1'b1;
                    pix_rec.kind  = K_WORD;
                    pix_rec.green = held_reg;
                    pix_rec.blue  = data_byte;
                end
            end
            FMT_C8:
            begin
                have         = 1'b1;
                pos          = b[4:0];
                pix_rec.kind = K_INDEX;
                pix_rec.blue = data_byte;
            end
            default:
            begin
                // ia8: alpha first, intensity second
                if (!b[0])
                begin
                    hold_wr = 1'b1;
                end
                else
                begin
                    have          = 1'b1;
                    pix_rec.alpha = held_reg;
                    pix_rec.red   = data_byte;
                    pix_rec.green = data_byte;
                    pix_rec.blue  = data_byte;
                end
            end
        endcase

        if (wide)
        begin
            px_full = {1'b0, col_reg} + {10'd0, pos[2:0]};
            py_full = {1'b0, row_reg} + {11'd0, pos[4:3]};
        end
        else
        begin
            px_full = {1'b0, col_reg} + {11'd0, pos[1:0]};
            py_full = {1'b0, row_reg} + {11'd0, pos[3:2]};
        end
        pix_rec.px = px_full[10:0];
        pix_rec.py = py_full[10:0];

        size_ok = (image_width != 12'd0) && ({1'b0, image_width} <= 13'(MAX_DIMENSION))
               && (image_height != 12'd0) && ({1'b0, image_height} <= 13'(MAX_DIMENSION));
        emit = have && size_ok && (px_full < {1'b0, image_width})
            && (py_full < {1'b0, image_height});

        // Tile advance
        col_sum = {1'b0, col_reg} + (wide ? 13'd8 : 13'd4);
        row_sum = {1'b0, row_reg} + 13'd4;
        bit_next = bit_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (byte_acc)
        begin
            if (last)
            begin
                bit_next = 6'd0;
                if (col_sum >= {1'b0, image_width})
                begin
                    col_next = 12'd0;
                    row_next = (row_sum >= {1'b0, image_height}) ? 12'd0 : row_sum[11:0];
                end
                else
                begin
                    col_next = col_sum[11:0];
                end
            end
            else
            begin
                bit_next = b + 6'd1;
            end
        end

        if (mode)
        begin
            q_rec       = '0;
            q_rec.kind  = K_PAL_WRITE;
            q_rec.alpha = palette_index;
            q_rec.green = palette_value[15:8];
            q_rec.blue  = palette_value[7:0];
        end
        else
        begin
            q_rec = pix_rec;
        end
        q_push = accept && (mode || emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= 6'd0;
            col_reg  <= 12'd0;
            row_reg  <= 12'd0;
            held_reg <= 8'd0;
        end
        else
        begin
            bit_reg <= bit_next;
            col_reg <= col_next;
            row_reg <= row_next;
            if (byte_acc && hold_wr)
            begin
                held_reg <= data_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_acc && even_wr)
        begin
            even_bank_reg[pidx] <= data_byte;
        end
        if (byte_acc && odd_wr)
        begin
            odd_bank_reg[pidx] <= data_byte;
        end
    end

endmodule

// ----- rtl/tdec_back.sv -----
// Back end: executes work records in order, owns the palette memory,
// expands colors and queues finished pixels. Depends on tdec_pkg, tdec_queue.
module tdec_back
    import tdec_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  rec_t       q_rec,
    output logic       q_pop,
    input  logic [8:0] palette_count,
    input  logic       out_pop,
    output logic       out_empty,
    output pix_t       out_pix
);

    localparam int PAW = $clog2(PALETTE_DEPTH);
    localparam int PIX_W = $bits(pix_t);

    logic [15:0]     pal_mem [PALETTE_DEPTH];
    logic [15:0]     pal_rd_reg;
    logic            sa_valid_reg, sa_valid_next;
    rec_t            sa_rec_reg;

    logic            is_pal;
    logic            pal_in_range;
    logic            out_full;
    logic            out_push;
    logic            load;
    logic            idx_ok;
    rgba_t           word_c;
    pix_t            pix;
    logic [PIX_W-1:0] out_bits;

    assign is_pal       = (q_rec.kind == K_PAL_WRITE);
    assign pal_in_range = ({1'b0, q_rec.alpha} < 9'(PALETTE_DEPTH));
    assign out_push     = sa_valid_reg && !out_full;
    assign load         = !q_empty && !is_pal && (!sa_valid_reg || out_push);
    assign q_pop        = (!q_empty && is_pal) || load;

    always_comb
    begin
        sa_valid_next = sa_valid_reg;
        if (load)
        begin
            sa_valid_next = 1'b1;
        end
        else if (out_push)
        begin
            sa_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
        end
        else
        begin
            sa_valid_reg <= sa_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sa_rec_reg <= q_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!q_empty && is_pal && pal_in_range)
        begin
            pal_mem[q_rec.alpha[PAW-1:0]] <= {q_rec.green, q_rec.blue};
        end
        if (load)
        begin
            pal_rd_reg <= pal_mem[q_rec.blue[PAW-1:0]];
        end
    end

    // Color stage
    always_comb
    begin
        idx_ok = ({1'b0, sa_rec_reg.blue} < palette_count)
              && ({1'b0, sa_rec_reg.blue} < 9'(PALETTE_DEPTH));
        word_c = expand_word((sa_rec_reg.kind == K_INDEX) ? pal_rd_reg
                                                          : {sa_rec_reg.green, sa_rec_reg.blue});
        pix.px = sa_rec_reg.px;
        pix.py = sa_rec_reg.py;
        case (sa_rec_reg.kind)
            K_WORD:
            begin
                pix.red   = word_c.red;
                pix.green = word_c.green;
                pix.blue  = word_c.blue;
                pix.alpha = word_c.alpha;
            end
            K_INDEX:
            begin
                if (idx_ok)
                begin
                    pix.red   = word_c.red;
                    pix.green = word_c.green;
                    pix.blue  = word_c.blue;
                    pix.alpha = word_c.alpha;
                end
                else
                begin
                    // grey fallback
                    pix.red   = sa_rec_reg.blue;
                    pix.green = sa_rec_reg.blue;
                    pix.blue  = sa_rec_reg.blue;
                    pix.alpha = 8'd255;
                end
            end
            default:
            begin
                pix.red   = sa_rec_reg.red;
                pix.green = sa_rec_reg.green;
                pix.blue  = sa_rec_reg.blue;
                pix.alpha = sa_rec_reg.alpha;
            end
        endcase
    end

    tdec_queue #(
        .WIDTH(PIX_W)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (out_full),
        .din   (pix),
        .pop   (out_pop),
        .empty (out_empty),
        .dout  (out_bits)
    );

    assign out_pix = pix_t'(out_bits);

    // A stalled color stage keeps its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        sa_valid_reg && out_full |=> sa_valid_reg && $stable(sa_rec_reg))
        else $error("color stage lost a stalled transaction");

    // A pixel record only enters when the color stage frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !is_pal |-> !sa_valid_reg || out_push)
        else $error("color stage overwritten");

    // Palette writes never disturb the color stage occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && is_pal && !out_push |=> sa_valid_reg == $past(sa_valid_reg))
        else $error("palette write changed color stage");

    // Palette write and pixel load never leave the queue together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(load && !q_empty && is_pal))
        else $error("palette write and pixel load in one cycle");

endmodule

// ----- rtl/tiled_texture_decoder_core.sv -----
// Tiled texture decoder top level: config registers, front end, work queue, back end.
// Path: a pixel passes the work queue, the color stage register and the output queue before it
// reaches the result ports. Throughput: one source byte or palette write per cycle while the work
// queue is not full, limited by the one-record-per-cycle work queue and palette memory port in the back end.
// Reset: asynchronous active low; clears tile position and queues, sets config to format 0, size 1x1, no palette.
// Depends on tdec_pkg, tdec_queue, tdec_front, tdec_back.
module tiled_texture_decoder_core
    import tdec_pkg::*;
#(
    parameter int MAX_DIMENSION = 2048,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  palette_index,
    input  logic [15:0] palette_value,
    output logic        empty,
    input  logic        pop,
    output logic [10:0] pixel_x,
    output logic [10:0] pixel_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int REC_W = $bits(rec_t);

    logic [1:0]       texture_format_reg;
    logic [11:0]      image_width_reg;
    logic [11:0]      image_height_reg;
    logic [8:0]       palette_count_reg;

    logic             accept;
    logic             q_push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    rec_t             q_in;
    logic [REC_W-1:0] q_out;
    pix_t             out_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texture_format_reg <= 2'd0;
            image_width_reg    <= 12'd1;
            image_height_reg   <= 12'd1;
            palette_count_reg  <= 9'd0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_FORMAT:  texture_format_reg <= cfg_data[1:0];
                CFG_WIDTH:   image_width_reg    <= cfg_data;
                CFG_HEIGHT:  image_height_reg   <= cfg_data;
                CFG_PALETTE: palette_count_reg  <= cfg_data[8:0];
                default:     texture_format_reg <= texture_format_reg;
            endcase
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    tdec_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .mode           (mode),
        .data_byte      (data_byte),
        .palette_index  (palette_index),
        .palette_value  (palette_value),
        .texture_format (texture_format_reg),
        .image_width    (image_width_reg),
        .image_height   (image_height_reg),
        .q_push         (q_push),
        .q_rec          (q_in)
    );

    tdec_queue #(
        .WIDTH(REC_W)
    ) u_work_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .din   (q_in),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_out)
    );

    tdec_back #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rec         (rec_t'(q_out)),
        .q_pop         (q_pop),
        .palette_count (palette_count_reg),
        .out_pop       (pop),
        .out_empty     (empty),
        .out_pix       (out_pix)
    );

    assign pixel_x = out_pix.px;
    assign pixel_y = out_pix.py;
    assign red     = out_pix.red;
    assign green   = out_pix.green;
    assign blue    = out_pix.blue;
    assign alpha   = out_pix.alpha;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tiled_texture_decoder_core: random and directed tile streams
// in all four formats, with an in-bench pixel predictor. Depends on tdec_pkg and the core RTL.
module tb_top;
    import tdec_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 240;

    typedef struct {
        logic        mode;
        logic [7:0]  data;
        logic [7:0]  pal_idx;
        logic [15:0] pal_word;
    } src_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        mode = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic [7:0]  palette_index = 8'd0;
    logic [15:0] palette_value = 16'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [11:0] cfg_data = 12'd0;

    // stimulus and scoreboard
    src_item_t   src_items[$];
    src_item_t   next_item;
    pix_t        expected_pixels[$];
    pix_t        want;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned err_cnt = 0;
    int unsigned cycles = 0;

    // predictor state and register shadows
    logic [15:0] pal_mem[256];
    logic [7:0]  ar_half[32];
    int unsigned tile_pos = 0;
    int unsigned col_org = 0;
    int unsigned row_org = 0;
    logic [7:0]  pair_hi = 8'd0;
    fmt_t        cur_fmt = FMT_RGBA8;
    int unsigned cur_w = 1;
    int unsigned cur_h = 1;
    int unsigned cur_pal_cnt = 0;

    tiled_texture_decoder_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .data_byte    (data_byte),
        .palette_index(palette_index),
        .palette_value(palette_value),
        .empty        (empty),
        .pop          (pop),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void unpack_rgb5a3(input logic [15:0] w, output logic [7:0] r,
                                          output logic [7:0] g, output logic [7:0] b,
                                          output logic [7:0] a);
        if (w[15])
        begin
            r = 8'(int'(w[14:10]) * 255 / 31);
            g = 8'(int'(w[9:5]) * 255 / 31);
            b = 8'(int'(w[4:0]) * 255 / 31);
            a = 8'd255;
        end
        else
        begin
            a = 8'(int'(w[14:12]) * 255 / 7);
            r = 8'(int'(w[11:8]) * 255 / 15);
            g = 8'(int'(w[7:4]) * 255 / 15);
            b = 8'(int'(w[3:0]) * 255 / 15);
        end
    endfunction

    // Takes a palette write, or steps the tile walk by one byte and queues any finished pixel.
    function automatic void decode_source_byte(input src_item_t it);
        int unsigned len;
        int unsigned tw;
        int unsigned b;
        int unsigned p;
        int unsigned px;
        int unsigned py;
        int unsigned col;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  bl;
        logic [7:0]  a;
        bit          have;
        pix_t        pix;
        if (it.mode)
        begin
            pal_mem[it.pal_idx] = it.pal_word;
            return;
        end
        len = (cur_fmt == FMT_RGBA8) ? 64 : 32;
        tw = (cur_fmt == FMT_C8) ? 8 : 4;
        b = tile_pos & (len - 1);
        p = 0;
        have = 1'b0;
        r = 8'd0;
        g = 8'd0;
        bl = 8'd0;
        a = 8'd0;
        case (cur_fmt)
            FMT_RGBA8:
            begin
                if (b < 32)
                    ar_half[b] = it.data;
                else if ((b & 1) == 0)
                    pair_hi = it.data;
                else
                begin
                    p = (b - 32) >> 1;
                    a = ar_half[(2 * p) & 31];
                    r = ar_half[(2 * p + 1) & 31];
                    g = pair_hi;
                    bl = it.data;
                    have = 1'b1;
                end
            end
            FMT_RGB5A3:
            begin
                if ((b & 1) == 0)
                    pair_hi = it.data;
                else
                begin
                    p = b >> 1;
                    unpack_rgb5a3({pair_hi, it.data}, r, g, bl, a);
                    have = 1'b1;
                end
            end
            FMT_C8:
            begin
                p = b;
                if (it.data < cur_pal_cnt)
                    unpack_rgb5a3(pal_mem[it.data], r, g, bl, a);
                else
                begin
                    // grey ramp for indexes outside the palette
                    r = it.data;
                    g = it.data;
                    bl = it.data;
                    a = 8'd255;
                end
                have = 1'b1;
            end
            default:
            begin
                if ((b & 1) == 0)
                    pair_hi = it.data;
                else
                begin
                    p = b >> 1;
                    a = pair_hi;
                    r = it.data;
                    g = it.data;
                    bl = it.data;
                    have = 1'b1;
                end
            end
        endcase
        px = col_org + ((tw == 8) ? (p & 7) : (p & 3));
        py = row_org + ((tw == 8) ? (p >> 3) : (p >> 2));
        if (have && cur_w >= 1 && cur_w <= 2048 && cur_h >= 1 && cur_h <= 2048 &&
            px < cur_w && py < cur_h)
        begin
            pix.px = 11'(px);
            pix.py = 11'(py);
            pix.red = r;
            pix.green = g;
            pix.blue = bl;
            pix.alpha = a;
            expected_pixels.push_back(pix);
        end
        if (b == len - 1)
        begin
            col = col_org + tw;
            tile_pos = 0;
            if (col >= cur_w)
            begin
                col_org = 0;
                row_org = (row_org + 4 >= cur_h) ? 0 : row_org + 4;
            end
            else
                col_org = col;
        end
        else
            tile_pos = b + 1;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            mode <= 1'b0;
            data_byte <= 8'd0;
            palette_index <= 8'd0;
            palette_value <= 16'd0;
            send_gap = 0;
        end
        else
        begin
            if (push && !full)
            begin
                next_item.mode = mode;
                next_item.data = data_byte;
                next_item.pal_idx = palette_index;
                next_item.pal_word = palette_value;
                decode_source_byte(next_item);
            end
            if (!(push && full))
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (src_items.size() != 0)
                begin
                    next_item = src_items.pop_front();
                    mode <= next_item.mode;
                    data_byte <= next_item.data;
                    palette_index <= next_item.pal_idx;
                    palette_value <= next_item.pal_word;
                    push <= 1'b1;
                    send_gap = tx_idle ? $urandom_range(0, 9) : 0;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            err_cnt++;
        end
    endtask

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel transaction at (%0d, %0d)", pixel_x, pixel_y);
                    err_cnt++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", 32'(want.px), 32'(pixel_x));
                    check_field("pixel_y", 32'(want.py), 32'(pixel_y));
                    check_field("red", 32'(want.red), 32'(red));
                    check_field("green", 32'(want.green), 32'(green));
                    check_field("blue", 32'(want.blue), 32'(blue));
                    check_field("alpha", 32'(want.alpha), 32'(alpha));
                end
                recv_stall = rx_idle ? $urandom_range(0, 9) : 0;
            end
            else if (recv_stall != 0)
                recv_stall--;
            pop <= (recv_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_byte(input logic [7:0] d);
        src_item_t it;
        it.mode = 1'b0;
        it.data = d;
        it.pal_idx = 8'($urandom);
        it.pal_word = 16'($urandom);
        src_items.push_back(it);
    endtask

    task automatic put_pal(input logic [7:0] idx, input logic [15:0] w);
        src_item_t it;
        it.mode = 1'b1;
        it.data = 8'($urandom);
        it.pal_idx = idx;
        it.pal_word = w;
        src_items.push_back(it);
    endtask

    // wait until every queued transaction is sent and every pixel has come back;
    // sampled mid-cycle so the driver's updates at the edge are settled
    task automatic drain();
        while (src_items.size() != 0 || push || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_FORMAT:  cur_fmt = fmt_t'(val[1:0]);
            CFG_WIDTH:   cur_w = 32'(val);
            CFG_HEIGHT:  cur_h = 32'(val);
            CFG_PALETTE: cur_pal_cnt = 32'(val[8:0]);
            default: ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_regs(input fmt_t f, input logic [11:0] w, input logic [11:0] h,
                            input logic [11:0] n);
        drain();
        write_reg(CFG_FORMAT, 12'(f));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_PALETTE, n);
    endtask

    function automatic logic [11:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 12'd0;      // invalid size
            1:       return 12'd4095;   // above the maximum
            2, 3:    return 12'd1;
            4, 5:    return 12'd2048;
            default: return 12'($urandom_range(1, 13));
        endcase
    endfunction

    function automatic logic [11:0] pick_pal_cnt();
        case ($urandom_range(0, 3))
            0:       return 12'd0;
            1:       return 12'd256;
            default: return 12'($urandom_range(1, 255));
        endcase
    endfunction

    initial
    begin
        fmt_t        f;
        int unsigned len;
        int unsigned n;
        int unsigned sent;
        logic [15:0] w;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one full RGBA8 tile first so every AR slot holds data
        set_regs(FMT_RGBA8, 12'd4, 12'd3, 12'd0);
        for (int k = 0; k < 64; k++)
            put_byte((k % 4 == 0) ? 8'h00 : (k % 4 == 1) ? 8'hFF : 8'($urandom));

        // load every palette entry, boundary words up front
        for (int i = 0; i < 256; i++)
        begin
            case (i)
                0:       w = 16'h0000;
                1:       w = 16'hFFFF;
                2:       w = 16'h7FFF;
                3:       w = 16'h8000;
                default: w = 16'($urandom);
            endcase
            put_pal(8'(i), w);
        end

        // both RGB5A3 encodings, extremes, two padding columns; tile left open
        set_regs(FMT_RGB5A3, 12'd2, 12'd1, 12'd0);
        put_byte(8'h80); put_byte(8'h00);
        put_byte(8'hFF); put_byte(8'hFF);
        put_byte(8'h7F); put_byte(8'hFF);
        put_byte(8'h00); put_byte(8'h00);

        // C8 picked up mid-tile: palette hits, grey above count, extreme index
        set_regs(FMT_C8, 12'd3, 12'd2, 12'd4);
        put_byte(8'd0); put_byte(8'd3); put_byte(8'd4); put_byte(8'd255); put_byte(8'd1);

        set_regs(FMT_IA8, 12'd1, 12'd1, 12'd256);
        put_byte(8'hFF); put_byte(8'h00); put_byte(8'h00); put_byte(8'hFF);

        // zero width: counters move, no pixels
        set_regs(FMT_IA8, 12'd0, 12'd1, 12'd256);
        put_byte(8'h12); put_byte(8'h34); put_byte(8'h56); put_byte(8'h78);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            f = fmt_t'($urandom_range(0, 3));
            set_regs(f, pick_dim(), pick_dim(), pick_pal_cnt());
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            len = (f == FMT_RGBA8) ? 64 : 32;
            n = len * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, len - 1);   // leave a tile open across the switch
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    put_pal(8'($urandom), 16'($urandom));
                put_byte(8'($urandom));
            end
            sent += n;
        end

        drain();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tdec_pkg.sv
rtl/tdec_queue.sv
rtl/tdec_front.sv
rtl/tdec_back.sv
rtl/tiled_texture_decoder_core.sv
tb/sv/tb_top.sv
